// File: rtl/gre_pkg.sv
// ----------------------------------------------------------------------------
// gre_pkg
// shared types, constants and helpers of the graph reachability engine
// ----------------------------------------------------------------------------
package gre_pkg;

	// graph size and field widths
	localparam int NODES     = 64;
	localparam int NODE_W    = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int FUNC_W    = 2;
	localparam int FIELD_W   = 6;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		FN_ENABLE = 2'd0,
		FN_ADD    = 2'd1,
		FN_REMOVE = 2'd2,
		FN_QUERY  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENABLE,
		ST_LINK_RD,
		ST_LINK_WR,
		ST_Q_INIT,
		ST_Q_RUN,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture the incoming transaction
		logic en_set;    // set the enable bit of node_a
		logic link_rd;   // read adjacency row of node_a
		logic link_wr;   // write modified row back
		logic q_init;    // clear reached and expanded sets
		logic q_run;     // one expansion step
		logic out_load;  // load the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic  q_done;   // nothing left to expand, no read in flight
		func_t func;     // operation of the held transaction
	} status_t;

	function automatic logic node_ok(input logic [FIELD_W-1:0] n);
		return (int'(n) < NODES);
	endfunction

	function automatic logic [NODE_W-1:0] node_idx(input logic [FIELD_W-1:0] n);
		return NODE_W'(n);
	endfunction

endpackage

// File: rtl/gre_ram.sv
// ----------------------------------------------------------------------------
// gre_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gre_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/gre_ctrl.sv
// ----------------------------------------------------------------------------
// gre_ctrl
// sequencing fsm and output valid register
// ----------------------------------------------------------------------------
module gre_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  gre_pkg::func_t   in_func,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  gre_pkg::status_t status,
	output gre_pkg::cmd_t    cmd
);
	import gre_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   slot_free;

	assign slot_free = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (in_func)
						FN_ENABLE: state_d = ST_ENABLE;
						FN_ADD, FN_REMOVE: state_d = ST_LINK_RD;
						FN_QUERY: state_d = ST_Q_INIT;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ENABLE: state_d = ST_FINISH;
			ST_LINK_RD: state_d = ST_LINK_WR;
			ST_LINK_WR: state_d = ST_FINISH;
			ST_Q_INIT: state_d = ST_Q_RUN;
			ST_Q_RUN: begin
				if (status.q_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_ENABLE: cmd.en_set = 1'b1;
			ST_LINK_RD: cmd.link_rd = 1'b1;
			ST_LINK_WR: cmd.link_wr = 1'b1;
			ST_Q_INIT: cmd.q_init = 1'b1;
			ST_Q_RUN: cmd.q_run = 1'b1;
			ST_FINISH: cmd.out_load = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/gre_dpath.sv
// ----------------------------------------------------------------------------
// gre_dpath
// adjacency memory, enable bits and reachability expansion
// ----------------------------------------------------------------------------
module gre_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gre_pkg::cmd_t               cmd,
	input  gre_pkg::func_t              in_func,
	input  logic [gre_pkg::FIELD_W-1:0] in_node_a,
	input  logic [gre_pkg::FIELD_W-1:0] in_node_b,
	output gre_pkg::status_t            status,
	output logic                        connected
);
	import gre_pkg::*;

	// held transaction
	func_t              func_q;
	logic [FIELD_W-1:0] node_a_q;
	logic [FIELD_W-1:0] node_b_q;

	logic [NODES-1:0] enabled_q;
	logic [NODES-1:0] row_valid_q;
	logic [NODES-1:0] reached_q;
	logic [NODES-1:0] expanded_q;
	logic             rd_inflight_s1;
	logic             row_ok_s1;
	logic             connected_q;

	logic              a_ok;
	logic              b_ok;
	logic [NODE_W-1:0] a_idx;
	logic [NODE_W-1:0] b_idx;
	logic [NODES-1:0]  start_mask;
	logic [NODES-1:0]  ram_rdata;
	logic [NODES-1:0]  row_data;
	logic [NODES-1:0]  merged;
	logic [NODES-1:0]  pending;
	logic [NODES-1:0]  pick_oh;
	logic [NODE_W-1:0] pick_idx;
	logic              pick_valid;
	logic [NODES-1:0]  wr_row;
	logic              ram_we;
	logic              ram_re;
	logic [NODE_W-1:0] ram_raddr;

	assign a_ok  = node_ok(node_a_q);
	assign b_ok  = node_ok(node_b_q);
	assign a_idx = node_idx(node_a_q);
	assign b_idx = node_idx(node_b_q);

	// rows never written read as empty
	always_comb begin
		row_data = '0;
		if (row_ok_s1) begin
			row_data = ram_rdata;
		end
	end

	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			start_mask[i] = a_ok && (a_idx == NODE_W'(i));
		end
	end

	// frontier: reached or start, enabled, not yet expanded
	assign merged     = rd_inflight_s1 ? (reached_q | row_data) : reached_q;
	assign pending    = (merged | start_mask) & enabled_q & ~expanded_q;
	assign pick_oh    = pending & (~pending + NODES'(1));
	assign pick_valid = |pending;

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < NODES; i++) begin
			if (pick_oh[i]) begin
				pick_idx = pick_idx | NODE_W'(i);
			end
		end
	end

	// row update for add and remove
	always_comb begin
		for (int i = 0; i < NODES; i++) begin
			if (b_idx == NODE_W'(i)) begin
				wr_row[i] = (func_q == FN_ADD);
			end else begin
				wr_row[i] = row_data[i];
			end
		end
	end

	assign ram_we    = cmd.link_wr && a_ok && b_ok;
	assign ram_re    = cmd.link_rd || (cmd.q_run && pick_valid);
	assign ram_raddr = cmd.link_rd ? a_idx : pick_idx;

	gre_ram #(
		.WIDTH(NODES),
		.DEPTH(NODES)
	) u_adj_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(a_idx),
		.wdata(wr_row),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= in_func;
			node_a_q <= in_node_a;
			node_b_q <= in_node_b;
		end
		if (ram_re) begin
			row_ok_s1 <= row_valid_q[ram_raddr];
		end
		if (cmd.out_load) begin
			connected_q <= (func_q == FN_QUERY) && b_ok && reached_q[b_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= '0;
			row_valid_q    <= '0;
			reached_q      <= '0;
			expanded_q     <= '0;
			rd_inflight_s1 <= 1'b0;
		end else begin
			if (cmd.en_set && a_ok) begin
				enabled_q[a_idx] <= 1'b1;
			end
			if (ram_we) begin
				row_valid_q[a_idx] <= 1'b1;
			end
			if (cmd.q_init) begin
				reached_q      <= '0;
				expanded_q     <= '0;
				rd_inflight_s1 <= 1'b0;
			end else if (cmd.q_run) begin
				reached_q      <= merged;
				expanded_q     <= expanded_q | pick_oh;
				rd_inflight_s1 <= pick_valid;
			end
		end
	end

	assign status.q_done = !rd_inflight_s1 && !pick_valid;
	assign status.func   = func_q;
	assign connected     = connected_q;

endmodule

// File: rtl/graph_reachability_engine.sv
// ----------------------------------------------------------------------------
// graph_reachability_engine
// directed graph store with enable, link add/remove and reachability query
// ----------------------------------------------------------------------------
// usage
//   input stream s_*: one transaction per operation (enable node, add link,
//   remove link, query). output stream m_*: exactly one result transaction
//   per input transaction, in order; connected is set only by a query whose
//   target is reachable over links leaving enabled nodes.
//   items are worked one at a time: s_tready is high only while the
//   controller is idle.
//   steps per transaction, from accept to result register loaded:
//     enable sets one enable bit, add or remove link is a read-modify-write of
//     one row of the adjacency ram, and a query expands the enabled start node
//     and every enabled node reached from it, each once, walking one adjacency
//     row per cycle through the single ram read port.
//   the controller returns to idle before the next transaction is taken.
//   reset clears the graph, the enable bits and the reached set at once
//   (row valid bits, no clearing sweep); the engine is ready right after.
//   a stalled receiver holds the result in the output register; the next
//   transaction is still accepted and runs, then waits until that register
//   frees.
// ----------------------------------------------------------------------------
module graph_reachability_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// func [1:0], node_a [7:2], node_b [13:8], zero [15:14]
	input  logic [gre_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// connected [0], zero [7:1]
	output logic [gre_pkg::M_TDATA_W-1:0] m_tdata
);
	import gre_pkg::*;

	// field split of the input transaction
	func_t              in_func;
	logic [FIELD_W-1:0] in_node_a;
	logic [FIELD_W-1:0] in_node_b;
	cmd_t               cmd;
	status_t            status;
	logic               connected;

	assign in_func   = func_t'(s_tdata[FUNC_W-1:0]);
	assign in_node_a = s_tdata[FUNC_W +: FIELD_W];
	assign in_node_b = s_tdata[FUNC_W + FIELD_W +: FIELD_W];

	gre_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.in_func (in_func),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	gre_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_func  (in_func),
		.in_node_a(in_node_a),
		.in_node_b(in_node_b),
		.status   (status),
		.connected(connected)
	);

	// result field in the low bit, rest padded
	assign m_tdata = {{(M_TDATA_W-1){1'b0}}, connected};

	// no result register overwrite while the receiver still holds one
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// only queries may report a reachable target
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && status.func != FN_QUERY) |=> !m_tdata[0])
		else $error("non-query result marked connected");

	// one transaction at a time: accepting closes the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction accepted while busy");

	// neither expansion nor a link write runs while the input side is open
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(cmd.q_run || cmd.link_wr))
		else $error("datapath busy while ready");

endmodule
